### hw/rtl/smpq_pkg.sv
// Shared types and constants for the stable min priority queue.
package smpq_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_QUERY = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] elem;
        logic [PRIO_WIDTH-1:0] prio;
    } entry_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ins;
    } cell_cmd_t;

endpackage

### hw/rtl/smpq_cell.sv
// One slot of the sorted chain: holds one entry and trades it with its neighbors.
module smpq_cell
    import smpq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      occupied,
    input  logic      left_stay,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output logic      stay,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // Keep this entry in place when it sorts at or ahead of the new one.
    assign stay  = occupied && (entry_reg.prio <= cmd.ins.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq)
        begin
            if (!stay)
            begin
                entry_next = left_stay ? cmd.ins : left_entry;
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### hw/rtl/stable_min_priority_queue_unit.sv
// Top level of the stable min priority queue: cell chain, fill count and result register.
//
// Usage:
//   Input channel (in_valid / in_stall, fields op, elem, prio) carries one
//   operation per transaction: enqueue, dequeue front, or status query.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   operation: front element and priority, count, empty/full flags, error.
//   Latency: the result is valid in the cycle after the input transaction.
//   Throughput: one operation per cycle unless the output stalls; every cell
//   of the chain compares its priority with the incoming one in parallel and
//   shifts in one step, so the chain itself never limits the rate.
//   Equal priorities leave in arrival order: a new entry goes behind every
//   stored entry whose priority is lower or equal.
//   Enqueue while full returns error 1, dequeue while empty returns error 2;
//   neither changes the stored state.
//   Reset empties the queue (count zero) and drops any pending result.
//   Stall: while a result waits with out_stall high, in_stall is raised and
//   the result holds; a new transaction is taken in the same cycle that the
//   pending result is taken.
module stable_min_priority_queue_unit
    import smpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [ELEM_WIDTH-1:0] elem,
    input  logic [PRIO_WIDTH-1:0] prio,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ELEM_WIDTH-1:0] front_elem,
    output logic [PRIO_WIDTH-1:0] front_prio,
    output logic [CNT_W-1:0]      count,
    output logic                  empty_res,
    output logic                  full_res,
    output logic [1:0]            error
);

    logic             accept;
    logic             is_empty;
    logic             is_full;
    op_t              op_in;
    cell_cmd_t        cmd;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    err_t             err_reg;
    err_t             err_next;
    logic             sorted_ok;

    logic   [CAPACITY-1:0] stay;
    entry_t                cell_entry [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op_in    = op_t'(op);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));

    // Gate the broadcast so that rejected operations leave the chain alone.
    always_comb
    begin
        cmd.enq      = accept && (op_in == OP_ENQ) && !is_full;
        cmd.deq      = accept && (op_in == OP_DEQ) && !is_empty;
        cmd.ins.elem = elem;
        cmd.ins.prio = prio;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic   occ;
            logic   l_stay;
            entry_t l_entry;
            entry_t r_entry;

            assign occ = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                // Nothing ahead of the head: the new entry lands here if it moves.
                assign l_stay  = 1'b1;
                assign l_entry = '0;
            end
            else
            begin : g_body
                assign l_stay  = stay[gi-1];
                assign l_entry = cell_entry[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_entry = '0;
            end
            else
            begin : g_mid
                assign r_entry = cell_entry[gi+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occ),
                .left_stay   (l_stay),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .stay        (stay[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            err_next       = ERR_NONE;
            unique case (op_in)
                OP_ENQ:
                begin
                    if (is_full)
                        err_next = ERR_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                OP_DEQ:
                begin
                    if (is_empty)
                        err_next = ERR_EMPTY;
                    else
                        count_next = count_reg - CNT_W'(1);
                end
                OP_QUERY, OP_SPARE:
                begin
                    err_next = ERR_NONE;
                end
                default:
                begin
                    err_next = ERR_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            err_reg       <= ERR_NONE;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    // Result fields read straight from the head cell and the count; both hold
    // while a result is stalled because no transaction is taken then.
    assign out_valid  = out_valid_reg;
    assign front_elem = is_empty ? '0 : cell_entry[0].elem;
    assign front_prio = is_empty ? '0 : cell_entry[0].prio;
    assign count      = count_reg;
    assign empty_res  = is_empty;
    assign full_res   = is_full;
    assign error      = err_reg;

    // Occupied cells stay in ascending priority order.
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int k = 1; k < CAPACITY; k++)
        begin
            if ((CNT_W'(k) < count_reg) && (cell_entry[k-1].prio > cell_entry[k].prio))
                sorted_ok = 1'b0;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("stored priorities out of order");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_in == OP_ENQ) && is_full) |=> (is_full && (err_reg == ERR_FULL)))
        else $error("enqueue while full changed state");

    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_in == OP_DEQ) && is_empty) |=> (is_empty && (err_reg == ERR_EMPTY)))
        else $error("dequeue while empty changed state");

endmodule
